[hdl/dps_pkg.sv]
`default_nettype none

package dps_pkg;

    localparam int SLOTS_DEFAULT = 8;

    localparam logic [7:0] BASE_PRIORITY_RESET = 8'd50;
    localparam logic [3:0] PRIORITY_STEP_RESET = 4'd3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic REG_BASE_PRIORITY = 1'b0;
    localparam logic REG_PRIORITY_STEP = 1'b1;

    localparam logic signed [13:0] PRIO_MIN = 14'sh2000;

    typedef struct packed {
        logic [7:0]         need;
        logic signed [13:0] prio;
        logic [7:0]         ticks;
    } entry_t;

    typedef struct packed {
        logic clear;
        logic sample;
    } track_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

[hdl/dps_slot_store.sv]
`default_nettype none

module dps_slot_store #(
    parameter int SLOTS = dps_pkg::SLOTS_DEFAULT,
    parameter int AW    = $clog2(SLOTS)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  dps_pkg::entry_t  wdata,
    input  logic [AW-1:0]    raddr,
    output dps_pkg::entry_t  rdata
);
    import dps_pkg::*;

    entry_t mem [SLOTS];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/dps_best_track.sv]
`default_nettype none

module dps_best_track #(
    parameter int AW = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dps_pkg::track_ctl_t  ctl,
    input  logic [AW-1:0]        cand_idx,
    input  dps_pkg::entry_t      cand,
    output logic                 found,
    output logic [AW-1:0]        best_idx,
    output dps_pkg::entry_t      best
);
    import dps_pkg::*;

    logic          found_reg;
    logic          found_next;
    logic [AW-1:0] best_idx_reg;
    entry_t        best_reg;
    logic          win;

    // strict greater-than keeps the lower index on a tie (ascending scan)
    assign win = ctl.sample && (!found_reg || (cand.prio > best_reg.prio));

    always_comb
    begin
        found_next = found_reg;
        if (ctl.clear)
        begin
            found_next = 1'b0;
        end
        else if (win)
        begin
            found_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win)
        begin
            best_idx_reg <= cand_idx;
            best_reg     <= cand;
        end
    end

    assign found    = found_reg;
    assign best_idx = best_idx_reg;
    assign best     = best_reg;

endmodule

`default_nettype wire

[hdl/dynamic_priority_scheduler.sv]
`default_nettype none

// Dynamic priority scheduler over SLOTS process slots held in a one-port-read
// slot memory. A load beat writes one slot (priority = base_priority - need)
// on acceptance and then passes through ST_DONE into the output register. A
// tick beat walks the slot memory one entry per cycle through a single
// compare unit that tracks the highest signed priority among slots with need
// left, then writes the charged slot back; its result passes through the scan
// states, a drain state for the last read to settle, the write back and the
// load of the output register. A result still waiting in the output register
// holds the block in ST_DONE for as long as out_ready stays low.
// The block takes one beat at a time: in_ready is high only between items,
// while a finished result may still wait in the output register.
// Configuration writes are registered and should be made while idle.
module dynamic_priority_scheduler #(
    parameter int SLOTS = dps_pkg::SLOTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_addr,
    input  logic [7:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [2:0]         slot_index,
    input  logic [7:0]         need_time,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               ran,
    output logic [2:0]         chosen_slot,
    output logic [7:0]         need_left,
    output logic [7:0]         ticks_used,
    output logic signed [13:0] new_priority,
    output logic               all_done
);
    import dps_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = (AW > 3) ? AW : 3;

    state_t         state_reg, state_next;
    logic [AW-1:0]  scan_cnt_reg, scan_cnt_next;
    logic           rd_pend_reg, rd_pend_next;
    logic [AW-1:0]  rd_idx_reg, rd_idx_next;
    logic [SLOTS-1:0] need_nz_reg, need_nz_next;
    logic [7:0]     base_reg;
    logic [3:0]     step_reg;

    logic           res_ran_reg, res_ran_next;
    logic [2:0]     res_slot_reg, res_slot_next;
    logic [7:0]     res_need_reg, res_need_next;
    logic [7:0]     res_ticks_reg, res_ticks_next;
    logic signed [13:0] res_prio_reg, res_prio_next;

    logic           out_valid_reg, out_valid_next;
    logic           out_ran_reg, out_ran_next;
    logic [2:0]     out_slot_reg, out_slot_next;
    logic [7:0]     out_need_reg, out_need_next;
    logic [7:0]     out_ticks_reg, out_ticks_next;
    logic signed [13:0] out_prio_reg, out_prio_next;
    logic           out_done_reg, out_done_next;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    entry_t         mem_wdata;
    entry_t         mem_rdata;

    track_ctl_t     trk_ctl;
    logic           found;
    logic [AW-1:0]  best_idx;
    entry_t         best;

    logic [CW:0]    idx_ext;
    logic           load_hit;
    logic [AW-1:0]  load_addr;
    entry_t         load_entry;
    entry_t         upd_entry;
    logic [14:0]    prio_dec;
    logic [CW-1:0]  best_ext;

    dps_slot_store #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (scan_cnt_reg),
        .rdata (mem_rdata)
    );

    dps_best_track #(
        .AW (AW)
    ) u_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (trk_ctl),
        .cand_idx (rd_idx_reg),
        .cand     (mem_rdata),
        .found    (found),
        .best_idx (best_idx),
        .best     (best)
    );

    // load decode
    assign idx_ext          = (CW+1)'(slot_index);
    assign load_hit         = idx_ext < (CW+1)'(SLOTS);
    assign load_addr        = idx_ext[AW-1:0];
    assign load_entry.need  = need_time;
    assign load_entry.prio  = {6'b0, base_reg} - {6'b0, need_time};
    assign load_entry.ticks = 8'd0;

    // charge the winner: saturate priority low, tick count high
    assign prio_dec        = {best.prio[13], best.prio} - {11'b0, step_reg};
    assign upd_entry.need  = best.need - 8'd1;
    assign upd_entry.prio  = (prio_dec[14] != prio_dec[13]) ? PRIO_MIN : prio_dec[13:0];
    assign upd_entry.ticks = (best.ticks == 8'hFF) ? 8'hFF : best.ticks + 8'd1;
    assign best_ext        = CW'(best_idx);

    always_comb
    begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        rd_pend_next   = 1'b0;
        rd_idx_next    = scan_cnt_reg;
        need_nz_next   = need_nz_reg;
        res_ran_next   = res_ran_reg;
        res_slot_next  = res_slot_reg;
        res_need_next  = res_need_reg;
        res_ticks_next = res_ticks_reg;
        res_prio_next  = res_prio_reg;
        out_valid_next = out_valid_reg;
        out_ran_next   = out_ran_reg;
        out_slot_next  = out_slot_reg;
        out_need_next  = out_need_reg;
        out_ticks_next = out_ticks_reg;
        out_prio_next  = out_prio_reg;
        out_done_next  = out_done_reg;
        in_ready       = (state_reg == ST_IDLE);
        mem_we         = 1'b0;
        mem_waddr      = best_idx;
        mem_wdata      = upd_entry;
        trk_ctl.clear  = 1'b0;
        trk_ctl.sample = rd_pend_reg && need_nz_reg[rd_idx_reg];

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_ran_next   = 1'b0;
                    res_slot_next  = 3'd0;
                    res_need_next  = 8'd0;
                    res_ticks_next = 8'd0;
                    res_prio_next  = 14'sd0;
                    if (cmd == CMD_TICK)
                    begin
                        trk_ctl.clear = 1'b1;
                        scan_cnt_next = '0;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        if (load_hit)
                        begin
                            mem_we                  = 1'b1;
                            mem_waddr               = load_addr;
                            mem_wdata               = load_entry;
                            need_nz_next[load_addr] = (need_time != 8'd0);
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_pend_next = 1'b1;
                if (scan_cnt_reg == AW'(SLOTS - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (found)
                begin
                    mem_we                 = 1'b1;
                    need_nz_next[best_idx] = (upd_entry.need != 8'd0);
                    res_ran_next           = 1'b1;
                    res_slot_next          = best_ext[2:0];
                    res_need_next          = upd_entry.need;
                    res_ticks_next         = upd_entry.ticks;
                    res_prio_next          = upd_entry.prio;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_ran_next   = res_ran_reg;
                    out_slot_next  = res_slot_reg;
                    out_need_next  = res_need_reg;
                    out_ticks_next = res_ticks_reg;
                    out_prio_next  = res_prio_reg;
                    out_done_next  = ~|need_nz_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            need_nz_reg   <= '0;
            out_valid_reg <= 1'b0;
            base_reg      <= BASE_PRIORITY_RESET;
            step_reg      <= PRIORITY_STEP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            need_nz_reg   <= need_nz_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_BASE_PRIORITY: base_reg <= cfg_wdata;
                    REG_PRIORITY_STEP: step_reg <= cfg_wdata[3:0];
                    default:           base_reg <= base_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        res_ran_reg   <= res_ran_next;
        res_slot_reg  <= res_slot_next;
        res_need_reg  <= res_need_next;
        res_ticks_reg <= res_ticks_next;
        res_prio_reg  <= res_prio_next;
        out_ran_reg   <= out_ran_next;
        out_slot_reg  <= out_slot_next;
        out_need_reg  <= out_need_next;
        out_ticks_reg <= out_ticks_next;
        out_prio_reg  <= out_prio_next;
        out_done_reg  <= out_done_next;
    end

    assign out_valid    = out_valid_reg;
    assign ran          = out_ran_reg;
    assign chosen_slot  = out_slot_reg;
    assign need_left    = out_need_reg;
    assign ticks_used   = out_ticks_reg;
    assign new_priority = out_prio_reg;
    assign all_done     = out_done_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted a beat while an item was still in flight");

    a_idle_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ran) |-> (chosen_slot == 3'd0 && need_left == 8'd0 &&
                                 ticks_used == 8'd0 && new_priority == 14'sd0))
        else $error("result fields nonzero without a charged slot");

    a_ran_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ran) |-> (ticks_used != 8'd0))
        else $error("charged slot reports zero ticks");

    a_winner_has_need: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE && found) |-> need_nz_reg[best_idx])
        else $error("selected slot has no remaining need");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg <= AW'(SLOTS - 1)))
        else $error("scan counter ran past the last slot");

endmodule

`default_nettype wire

[test/tb_dynamic_priority_scheduler.sv]
`timescale 1ns / 1ps

import dps_pkg::*;

localparam int PRIO_CEIL = 8191;

typedef struct packed {
    logic               ran;
    logic [2:0]         chosen_slot;
    logic [7:0]         need_left;
    logic [7:0]         ticks_used;
    logic signed [13:0] new_priority;
    logic               all_done;
} sched_result_t;

class sched_scoreboard;
    logic [7:0]    base_priority;
    logic [3:0]    priority_step;
    logic [7:0]    need_tbl [SLOTS_DEFAULT];
    int            prio_tbl [SLOTS_DEFAULT];
    logic [7:0]    ticks_tbl [SLOTS_DEFAULT];
    sched_result_t due_results [$];
    int            errors;

    function new();
        int i;
        base_priority = BASE_PRIORITY_RESET;
        priority_step = PRIORITY_STEP_RESET;
        errors = 0;
        for (i = 0; i < SLOTS_DEFAULT; i++)
        begin
            need_tbl[i]  = 8'd0;
            prio_tbl[i]  = 0;
            ticks_tbl[i] = 8'd0;
        end
    endfunction

    function void write_reg(logic addr, logic [7:0] data);
        if (addr == REG_BASE_PRIORITY)
            base_priority = data;
        else
            priority_step = data[3:0];
    endfunction

    // Work out the result of one accepted beat and update the slot table.
    function void accept_beat(logic op, logic [2:0] slot, logic [7:0] need);
        sched_result_t r;
        int            best;
        int            p;
        int            i;
        r    = '0;
        best = -1;
        if (op == CMD_LOAD)
        begin
            if (int'(slot) < SLOTS_DEFAULT)
            begin
                need_tbl[slot]  = need;
                prio_tbl[slot]  = int'(base_priority) - int'(need);
                ticks_tbl[slot] = 8'd0;
            end
        end
        else
        begin
            // strict compare keeps the lowest index on a tie
            for (i = 0; i < SLOTS_DEFAULT; i++)
                if (need_tbl[i] != 8'd0 && (best < 0 || prio_tbl[i] > prio_tbl[best]))
                    best = i;
            if (best >= 0)
            begin
                p = prio_tbl[best] - int'(priority_step);
                if (p < int'(PRIO_MIN))
                    p = int'(PRIO_MIN);
                if (p > PRIO_CEIL)
                    p = PRIO_CEIL;
                prio_tbl[best] = p;
                need_tbl[best] = need_tbl[best] - 8'd1;
                if (ticks_tbl[best] != 8'hFF)
                    ticks_tbl[best] = ticks_tbl[best] + 8'd1;
                r.ran          = 1'b1;
                r.chosen_slot  = best[2:0];
                r.need_left    = need_tbl[best];
                r.ticks_used   = ticks_tbl[best];
                r.new_priority = p[13:0];
            end
        end
        r.all_done = 1'b1;
        for (i = 0; i < SLOTS_DEFAULT; i++)
            if (need_tbl[i] != 8'd0)
                r.all_done = 1'b0;
        due_results.push_back(r);
    endfunction

    task report(string what, int got, int want);
        errors++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task check_beat(sched_result_t got);
        sched_result_t want;
        if (due_results.size() == 0)
        begin
            report("unexpected result beat", 1, 0);
            return;
        end
        want = due_results.pop_front();
        if (got.ran != want.ran)
            report("ran", got.ran, want.ran);
        if (got.chosen_slot != want.chosen_slot)
            report("chosen_slot", got.chosen_slot, want.chosen_slot);
        if (got.need_left != want.need_left)
            report("need_left", got.need_left, want.need_left);
        if (got.ticks_used != want.ticks_used)
            report("ticks_used", got.ticks_used, want.ticks_used);
        if (got.new_priority !== want.new_priority)
            report("new_priority", got.new_priority, want.new_priority);
        if (got.all_done != want.all_done)
            report("all_done", got.all_done, want.all_done);
    endtask
endclass

module tb_dynamic_priority_scheduler;
    localparam int SLOTS        = SLOTS_DEFAULT;
    localparam int TICK_LATENCY = SLOTS + 4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 200;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_addr;
    logic [7:0]         cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic               cmd;
    logic [2:0]         slot_index;
    logic [7:0]         need_time;
    logic               out_valid;
    logic               out_ready;
    logic               ran;
    logic [2:0]         chosen_slot;
    logic [7:0]         need_left;
    logic [7:0]         ticks_used;
    logic signed [13:0] new_priority;
    logic               all_done;

    logic            calm;
    int              stall_left;
    int              cycles = 0;
    int              sent;
    sched_scoreboard sb;

    dynamic_priority_scheduler i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .slot_index   (slot_index),
        .need_time    (need_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .ran          (ran),
        .chosen_slot  (chosen_slot),
        .need_left    (need_left),
        .ticks_used   (ticks_used),
        .new_priority (new_priority),
        .all_done     (all_done)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("dynamic_priority_scheduler test failed");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_beat({ran, chosen_slot, need_left, ticks_used, new_priority, all_done});

    // Result side: stall in short bursts unless the run has gone calm.
    initial
    begin
        out_ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 5);
            end
        end
    end

    task automatic send_item(logic op, logic [2:0] slot, logic [7:0] need);
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 5)) @(negedge clk);
        in_valid   <= 1'b1;
        cmd        <= op;
        slot_index <= slot;
        need_time  <= need;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.accept_beat(op, slot, need);
        sent++;
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Tick beats carry random slot and need bits, which the block must ignore.
    task automatic send_tick();
        send_item(CMD_TICK, 3'($urandom), 8'($urandom));
    endtask

    task automatic write_reg(logic addr, logic [7:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(addr, data);
    endtask

    task automatic wait_drained();
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (TICK_LATENCY + 4) @(negedge clk);
    endtask

    task automatic clear_slots();
        int s;
        for (s = 0; s < SLOTS; s++)
            send_item(CMD_LOAD, 3'(s), 8'd0);
    endtask

    // Load a few slots, then tick roughly long enough to use up their need, with a load mixed in now and then.
    task automatic run_episode();
        int loads;
        int work;
        int need;
        if ($urandom_range(0, 5) == 0)
            clear_slots();
        loads = $urandom_range(1, SLOTS);
        work  = 0;
        repeat (loads)
        begin
            need = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, 12);
            send_item(CMD_LOAD, 3'($urandom_range(0, SLOTS - 1)), 8'(need));
            work += need;
        end
        if (work > 60)
            work = 60;
        repeat (work + $urandom_range(0, 3))
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(CMD_LOAD, 3'($urandom),
                          ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8)));
            else
                send_tick();
        end
    endtask

    initial
    begin
        logic [7:0] base_sel [8];
        logic [3:0] step_sel [8];
        int         phase;
        int         phase_start;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = REG_BASE_PRIORITY;
        cfg_wdata  = 8'd0;
        in_valid   = 1'b0;
        cmd        = CMD_LOAD;
        slot_index = 3'd0;
        need_time  = 8'd0;
        calm       = 1'b0;
        sent       = 0;
        sb         = new();
        base_sel   = '{8'd50, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0};
        step_sel   = '{4'd3, 4'd0, 4'd15, 4'd15, 4'd0, 4'd0, 4'd15, 4'd0};
        base_sel[5] = 8'($urandom);
        step_sel[5] = 4'($urandom);
        base_sel[7] = 8'($urandom);
        step_sel[7] = 4'($urandom);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // empty table: nothing runs
        send_item(CMD_TICK, 3'd5, 8'hFF);
        // zero-need slot is never picked
        send_item(CMD_LOAD, 3'd0, 8'd0);
        send_item(CMD_TICK, 3'd7, 8'd0);
        send_item(CMD_LOAD, 3'd7, 8'd255);
        // equal priorities: lowest index goes first
        send_item(CMD_LOAD, 3'd2, 8'd10);
        send_item(CMD_LOAD, 3'd5, 8'd10);
        send_tick();
        send_tick();
        send_tick();
        send_item(CMD_LOAD, 3'd3, 8'd1);
        send_tick();
        send_tick();
        send_item(CMD_LOAD, 3'd4, 8'd128);
        send_item(CMD_LOAD, 3'd6, 8'd50);
        send_item(CMD_LOAD, 3'd1, 8'd0);
        send_tick();
        wait_drained();
        write_reg(REG_BASE_PRIORITY, 8'd255);
        write_reg(REG_PRIORITY_STEP, 8'd15);
        send_item(CMD_LOAD, 3'd0, 8'd255);
        send_item(CMD_LOAD, 3'd1, 8'd0);
        send_tick();
        send_tick();
        send_tick();
        wait_drained();

        for (phase = 0; phase < 8; phase++)
        begin
            write_reg(REG_BASE_PRIORITY, base_sel[phase]);
            write_reg(REG_PRIORITY_STEP, {4'h0, step_sel[phase]});
            calm        = (phase == 7);
            phase_start = sent;
            if (phase == 6)
            begin
                // run one slot from full need down to zero
                clear_slots();
                send_item(CMD_LOAD, 3'd6, 8'd255);
                repeat (256) send_tick();
            end
            while (sent - phase_start < PHASE_ITEMS)
                run_episode();
            wait_drained();
        end

        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("dynamic_priority_scheduler test passed");
        else
            $display("dynamic_priority_scheduler test failed");
        $finish;
    end
endmodule
